// ----- sv/tcce_pkg.sv -----
// ----------------------------------------------------------------------------
// tcce_pkg: shared types and constants of the ternary cube compare engine
// Code values, lane split and the records passed between lanes and merge.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

	localparam int WORD_W         = 32;
	localparam int NUM_PAIRS      = WORD_W / 2;
	localparam int NUM_LANES      = 4;
	localparam int PAIRS_PER_LANE = NUM_PAIRS / NUM_LANES;
	localparam int LANE_BITS      = 2 * PAIRS_PER_LANE;
	localparam int LIVE_W         = 5;
	localparam int CNT_W          = 11;
	localparam int LCNT_W         = $clog2(PAIRS_PER_LANE + 1);
	localparam int SUM_W          = $clog2(NUM_PAIRS + 1);

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	// positional cube codes
	localparam logic [1:0] CODE_EMPTY = 2'b00;
	localparam logic [1:0] CODE_FREE  = 2'b11;

	// result select
	localparam logic REQ_INTERSECT = 1'b0;
	localparam logic REQ_COFACTOR  = 1'b1;

	typedef struct packed {
		logic [LANE_BITS-1:0] word;
		logic                 empty;
		logic                 uncont;
		logic [LCNT_W-1:0]    differ;
		logic [LCNT_W-1:0]    free_a;
		logic [LCNT_W-1:0]    free_b;
	} lane_res_t;

	typedef struct packed {
		logic             contain;
		logic             compat;
		logic [CNT_W-1:0] differ;
		logic [CNT_W-1:0] free_a;
		logic [CNT_W-1:0] free_b;
	} totals_t;

	typedef struct packed {
		logic take;
		logic last;
	} merge_ctl_t;

endpackage

`default_nettype wire

// ----- sv/tcce_lane.sv -----
// ----------------------------------------------------------------------------
// tcce_lane: per-lane cube logic
// Works on one slice of variable pairs: result word slice, empty and
// containment flags, and small counts for differ and one-sided don't-care.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_lane (
	input  logic                                sel,
	input  logic [tcce_pkg::LANE_BITS-1:0]      a,
	input  logic [tcce_pkg::LANE_BITS-1:0]      b,
	input  logic [tcce_pkg::PAIRS_PER_LANE-1:0] live,
	output tcce_pkg::lane_res_t                 res
);
	import tcce_pkg::*;

	always_comb begin
		logic [1:0] aa;
		logic [1:0] bb;
		res = '0;
		for (int j = 0; j < PAIRS_PER_LANE; j++) begin
			aa = a[2*j +: 2];
			bb = b[2*j +: 2];
			if (sel == REQ_COFACTOR) begin
				res.word[2*j +: 2] = (bb == CODE_FREE) ? aa : bb;
			end else begin
				res.word[2*j +: 2] = aa & bb;
			end
			if (live[j] && ((aa & bb) == CODE_EMPTY)) res.empty = 1'b1;
			if ((bb & ~aa) != 2'b00) res.uncont = 1'b1;
			res.differ = res.differ + LCNT_W'(aa != bb);
			res.free_a = res.free_a + LCNT_W'((aa == CODE_FREE) && (bb != CODE_FREE));
			res.free_b = res.free_b + LCNT_W'((bb == CODE_FREE) && (aa != CODE_FREE));
		end
	end

endmodule

`default_nettype wire

// ----- sv/tcce_merge.sv -----
// ----------------------------------------------------------------------------
// tcce_merge: lane merge, running totals and output register
// Sums lane counts, folds flags, updates saturating totals and drives the
// output register; totals return to reset values after a last word.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_merge (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tcce_pkg::merge_ctl_t            ctl,
	input  tcce_pkg::lane_res_t             lanes [tcce_pkg::NUM_LANES],
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [tcce_pkg::WORD_W-1:0]     out_word,
	output logic                            out_last,
	output tcce_pkg::totals_t               out_totals
);
	import tcce_pkg::*;

	totals_t              acc_q;
	totals_t              acc_nxt;
	logic [WORD_W-1:0]    word_cat;
	logic [SUM_W-1:0]     sum_differ;
	logic [SUM_W-1:0]     sum_free_a;
	logic [SUM_W-1:0]     sum_free_b;
	logic                 any_empty;
	logic                 any_uncont;
	logic                 out_valid_q;
	logic [WORD_W-1:0]    out_word_q;
	logic                 out_last_q;
	totals_t              out_totals_q;

	function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] acc,
	                                            logic [SUM_W-1:0] add);
		logic [CNT_W:0] s;
		s = {1'b0, acc} + (CNT_W+1)'(add);
		return s[CNT_W] ? COUNT_MAX : s[CNT_W-1:0];
	endfunction

	always_comb begin
		sum_differ = '0;
		sum_free_a = '0;
		sum_free_b = '0;
		any_empty  = 1'b0;
		any_uncont = 1'b0;
		word_cat   = '0;
		for (int l = 0; l < NUM_LANES; l++) begin
			word_cat[l*LANE_BITS +: LANE_BITS] = lanes[l].word;
			sum_differ = sum_differ + SUM_W'(lanes[l].differ);
			sum_free_a = sum_free_a + SUM_W'(lanes[l].free_a);
			sum_free_b = sum_free_b + SUM_W'(lanes[l].free_b);
			any_empty  = any_empty | lanes[l].empty;
			any_uncont = any_uncont | lanes[l].uncont;
		end
		acc_nxt.contain = acc_q.contain & ~any_uncont;
		acc_nxt.compat  = acc_q.compat & ~any_empty;
		acc_nxt.differ  = sat_add(acc_q.differ, sum_differ);
		acc_nxt.free_a  = sat_add(acc_q.free_a, sum_free_a);
		acc_nxt.free_b  = sat_add(acc_q.free_b, sum_free_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '{contain: 1'b1, compat: 1'b1, default: '0};
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.take) begin
				out_valid_q <= 1'b1;
				if (ctl.last) begin
					acc_q <= '{contain: 1'b1, compat: 1'b1, default: '0};
				end else begin
					acc_q <= acc_nxt;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			out_word_q   <= word_cat;
			out_last_q   <= ctl.last;
			out_totals_q <= ctl.last ? acc_nxt : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_word   = out_word_q;
	assign out_last   = out_last_q;
	assign out_totals = out_totals_q;

endmodule

`default_nettype wire

// ----- sv/ternary_cube_compare_engine_top.sv -----
// Path: a word transfers in, is registered in the lane stage, then in the merge/output register, and transfers out.
// Throughput: one word per cycle; the lane stage and the merge/output register both
// advance every cycle unless the output side stalls.
// Reset: arst_n clears the stage valids and sets the totals to contain=1, compat=1,
// counts zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
// ternary_cube_compare_engine_top: streaming cube intersect/cofactor and compare
// Four lanes each handle four variable pairs of a word; a merge stage joins the
// word slices, folds the flags and keeps saturating totals reported on tlast.
// ----------------------------------------------------------------------------
`default_nettype none

module ternary_cube_compare_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // word_a[31:0], word_b[63:32], live_pairs[68:64], zero pad
	input  logic        s_axis_tuser,  // req_type
	input  logic        s_axis_tlast,  // last_word
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // word_out[31:0], b_within_a[32], compatible[33],
	                                   // differ_count[44:34], only_a_free[55:45],
	                                   // only_b_free[66:56], zero pad
	output logic        m_axis_tlast   // last_out
);
	import tcce_pkg::*;

	logic [WORD_W-1:0]    word_a;
	logic [WORD_W-1:0]    word_b;
	logic [LIVE_W-1:0]    live_pairs;
	logic [NUM_PAIRS-1:0] live_mask;
	lane_res_t            lane_res [NUM_LANES];
	lane_res_t            lane_s1  [NUM_LANES];
	logic                 vld_s1;
	logic                 last_s1;
	logic                 en_out;
	logic                 en_s1;
	logic                 in_xfer;
	merge_ctl_t           mctl;
	logic [WORD_W-1:0]    out_word;
	totals_t              out_totals;

	assign word_a     = s_axis_tdata[31:0];
	assign word_b     = s_axis_tdata[63:32];
	assign live_pairs = s_axis_tdata[68:64];

	// Pair k (counted from bit 0) is live when it lies within the top live_pairs
	// pairs; values above the word size simply mark every pair live.
	always_comb begin
		for (int k = 0; k < NUM_PAIRS; k++) begin
			live_mask[k] = ((LIVE_W+1)'(live_pairs) + (LIVE_W+1)'(k))
			               >= (LIVE_W+1)'(NUM_PAIRS);
		end
	end

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		tcce_lane u_lane (
			.sel  (s_axis_tuser),
			.a    (word_a[l*LANE_BITS +: LANE_BITS]),
			.b    (word_b[l*LANE_BITS +: LANE_BITS]),
			.live (live_mask[l*PAIRS_PER_LANE +: PAIRS_PER_LANE]),
			.res  (lane_res[l])
		);
	end

	// Output register frees when empty or being taken; the lane stage
	// advances whenever it is empty or can hand over to the merge.
	assign en_out        = !m_axis_tvalid || m_axis_tready;
	assign en_s1         = !vld_s1 || en_out;
	assign s_axis_tready = en_s1;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en_s1) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	// hold lane results while stalled
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			lane_s1 <= lane_res;
			last_s1 <= s_axis_tlast;
		end
	end

	assign mctl.take = vld_s1 && en_out;
	assign mctl.last = last_s1;

	tcce_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (mctl),
		.lanes      (lane_s1),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_word   (out_word),
		.out_last   (m_axis_tlast),
		.out_totals (out_totals)
	);

	assign m_axis_tdata = {5'b0, out_totals.free_b, out_totals.free_a, out_totals.differ,
	                       out_totals.compat, out_totals.contain, out_word};

`ifndef SYNTHESIS
	// an accepted word always occupies the lane stage on the next cycle
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> vld_s1)
		else $error("accepted word missing from lane stage");

	// a lane-stage word blocked by the output side keeps its contents
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !en_out) |=> (vld_s1 && $stable(last_s1) && $stable(lane_s1[0].word)))
		else $error("lane stage changed while stalled");

	// totals are only reported on a last word
	a_totals_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[66:32] == '0))
		else $error("totals nonzero on a word that is not last");
`endif

endmodule

`default_nettype wire
